/* rtl/stis_pkg.sv */
// -----------------------------------------------------------------------------
// Sorted ID table search package
// Shared sizes, command codes and the control state type of the search unit.
// -----------------------------------------------------------------------------
package stis_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 4096;
   localparam int KEY_WIDTH   = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // Fixed field widths of the request and response.
   localparam int INDEX_W = 12;
   localparam int POS_W   = 12;
   localparam int ID_W    = 64;
   localparam int COUNT_W = 13;

   // Search bounds carry a sign so that an empty range (high below low) is visible.
   localparam int BOUND_W = ADDR_W + 2;

   // One table word holds the identifier over the stored position.
   localparam int WORD_W = KEY_WIDTH + POS_W;

   // Request commands.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   // Control states of the search sequencer.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_RESULT
   } state_type;

endpackage

/* rtl/stis_if.sv */
// -----------------------------------------------------------------------------
// Sorted ID table search channels
// Valid/ready channels for requests, responses and the table count register.
// -----------------------------------------------------------------------------

// Request channel: table writes and searches.
interface stis_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [stis_pkg::INDEX_W-1:0] entry_index;
   logic [stis_pkg::ID_W-1:0]    entry_id;
   logic [stis_pkg::POS_W-1:0]   entry_position;
   logic [stis_pkg::ID_W-1:0]    search_key;

   modport source (output valid, cmd, entry_index, entry_id, entry_position, search_key,
                   input ready);
   modport sink   (input valid, cmd, entry_index, entry_id, entry_position, search_key,
                   output ready);
endinterface

// Response channel: one response per search.
interface stis_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       found;
   logic [stis_pkg::POS_W-1:0] position;

   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

// Register write channel for the table count.
interface stis_csr_if;
   logic                         valid;
   logic                         ready;
   logic [stis_pkg::COUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/sorted_id_table_search_unit.sv */
// -----------------------------------------------------------------------------
// Sorted ID table search unit
// Binary search over a table of (identifier, position) entries held in one
// synchronous RAM. Writes fill the table; searches return found and position.
// -----------------------------------------------------------------------------
// A write lands in the table when accepted. A search reads the first midpoint,
// then runs S halving steps, at most log2(depth)+1 = 13 for 4096 entries; each
// step is one RAM read and one compare.
// Only one search at a time; the next request is taken once the result
// moves to the response register. Reset clears control and the count register;
// the table contents are undefined until written and need no clearing pass.
module sorted_id_table_search_unit (
   input  logic       clock,
   input  logic       reset,
   stis_req_if.sink   req_chan,
   stis_rsp_if.source rsp_chan,
   stis_csr_if.sink   csr_chan
);
   import stis_pkg::*;

   // Table RAM and its registered read port.
   logic [WORD_W-1:0] table_mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   // Control and datapath registers.
   state_type                state_ff, state_in;
   logic [COUNT_W-1:0]       count_ff;
   logic signed [BOUND_W-1:0] low_ff, low_in;
   logic signed [BOUND_W-1:0] high_ff, high_in;
   logic [KEY_WIDTH-1:0]     key_ff, key_in;
   logic                     hit_ff, hit_in;
   logic [POS_W-1:0]         hit_pos_ff, hit_pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_found_ff;
   logic [POS_W-1:0]         rsp_position_ff;

   // Decode signals.
   logic                      req_accept;
   logic                      is_search;
   logic                      rsp_free;
   logic [COUNT_W-1:0]        count_sat;
   logic signed [BOUND_W-1:0] high_init;
   logic signed [BOUND_W-1:0] mid_cur;
   logic [KEY_WIDTH-1:0]      id_rd;
   logic [POS_W-1:0]          pos_rd;
   logic                      id_lt;
   logic                      id_eq;
   logic                      range_one;
   logic                      keep_going;
   logic signed [BOUND_W-1:0] next_low;
   logic signed [BOUND_W-1:0] next_high;
   logic                      next_empty;
   logic signed [BOUND_W-1:0] mid_next;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign is_search  = (req_chan.cmd == CMD_SEARCH);
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // Initial upper bound: the count saturated to the table depth, minus one.
   assign count_sat = (count_ff > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_ff;
   assign high_init = BOUND_W'(count_sat) - BOUND_W'(1);

   // Compare the entry read at the current midpoint against the key.
   assign mid_cur   = (low_ff + high_ff) >>> 1;
   assign id_rd     = rd_data_ff[WORD_W-1:POS_W];
   assign pos_rd    = rd_data_ff[POS_W-1:0];
   assign id_lt     = (id_rd < key_ff);
   assign id_eq     = (id_rd == key_ff);
   assign range_one = (low_ff == high_ff);

   // Narrow the range: above the midpoint when the entry is low, below otherwise.
   assign keep_going = id_lt || (!range_one && !id_eq);
   assign next_low   = id_lt ? (mid_cur + BOUND_W'(1)) : low_ff;
   assign next_high  = id_lt ? high_ff : (mid_cur - BOUND_W'(1));
   assign next_empty = (next_low > next_high);
   assign mid_next   = (next_low + next_high) >>> 1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_search) begin
               state_in = (count_sat == '0) ? ST_RESULT : ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (!keep_going || next_empty) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshakes, RAM strobes and datapath updates.
   // In idle the request side is always ready, so valid alone marks an accept.
   always_comb begin
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      low_in         = low_ff;
      high_in        = high_ff;
      key_in         = key_ff;
      hit_in         = hit_ff;
      hit_pos_in     = hit_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid && is_search) begin
               low_in     = '0;
               high_in    = high_init;
               key_in     = req_chan.search_key[KEY_WIDTH-1:0];
               hit_in     = 1'b0;
               hit_pos_in = '0;
               rd_en      = 1'b1;
               rd_addr    = high_init[ADDR_W:1];
            end else if (req_chan.valid) begin
               wr_en = ({1'b0, req_chan.entry_index} < (INDEX_W+1)'(TABLE_DEPTH));
            end
         end
         ST_COMPARE: begin
            low_in  = next_low;
            high_in = next_high;
            if (keep_going) begin
               rd_en   = !next_empty;
               rd_addr = mid_next[ADDR_W-1:0];
            end else begin
               hit_in     = !id_lt && id_eq;
               hit_pos_in = (!id_lt && id_eq) ? pos_rd : '0;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Table RAM: one write port for table loads, one read port for the search.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_chan.entry_index[ADDR_W-1:0]] <=
            {req_chan.entry_id[KEY_WIDTH-1:0], req_chan.entry_position};
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            count_ff <= csr_chan.data;
         end
      end
   end

   // Datapath registers; the response payload loads as the result leaves the sequencer.
   always_ff @(posedge clock) begin
      low_ff     <= low_in;
      high_ff    <= high_in;
      key_ff     <= key_in;
      hit_ff     <= hit_in;
      hit_pos_ff <= hit_pos_in;
      if (state_ff == ST_RESULT && rsp_free) begin
         rsp_found_ff    <= hit_ff;
         rsp_position_ff <= hit_pos_ff;
      end
   end

   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_position_ff;

   // A compare step only runs on a nonempty range.
   a_compare_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPARE |-> low_ff <= high_ff)
      else $error("search range empty during compare");

   // A miss always reports position zero.
   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_position_ff == '0)
      else $error("miss response carries a nonzero position");

   // The result state is entered only from idle or a compare step.
   a_result_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT && $past(state_ff) != ST_RESULT && !$past(reset)
      |-> $past(state_ff) == ST_COMPARE || $past(state_ff) == ST_IDLE)
      else $error("result state entered from an unexpected state");

   // A new response is raised only when the previous one was taken or absent.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid_ff) && !$past(rsp_chan.ready) && !$past(reset) |-> rsp_valid_ff)
      else $error("pending response dropped");

endmodule
